@@ rtl/monochrome_page_framebuffer_draw_top_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the page-mode frame store drawing block
// Shared property wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MONOCHROME_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH
`define MONOCHROME_PAGE_FRAMEBUFFER_DRAW_TOP_DEFINES_SVH

// Check a property on every clock edge outside reset
`define MPFD_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check a property on every clock edge, reset included
`define MPFD_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

@@ rtl/mpfd_pkg.sv @@
// ----------------------------------------------------------------------------
// mpfd_pkg
// Types, geometry constants and helpers for the page-mode frame store.
// ----------------------------------------------------------------------------
package mpfd_pkg;

   localparam int COLUMNS = 128;
   localparam int PAGES   = 8;
   localparam int DEPTH   = PAGES * COLUMNS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int ROWS    = PAGES * 8;

   localparam int NUM_W = 12;
   localparam int DEN_W = 8;

   localparam logic [2:0] ACT_FILL   = 3'd0;
   localparam logic [2:0] ACT_POINT  = 3'd1;
   localparam logic [2:0] ACT_LINE   = 3'd2;
   localparam logic [2:0] ACT_CIRCLE = 3'd3;
   localparam logic [2:0] ACT_READ   = 3'd4;

   localparam logic [7:0] FILL_ONES  = 8'hFF;
   localparam logic [7:0] FILL_ZEROS = 8'h00;

   typedef struct packed {
      logic [2:0] action;
      logic       ink;
      logic [7:0] x_start;
      logic [7:0] y_start;
      logic [7:0] x_end;
      logic [7:0] y_end;
      logic [7:0] radius;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       clipped;
   } rsp_payload_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

   function automatic logic off_screen(logic [7:0] x, logic [7:0] y);
      off_screen = ({1'b0, x} >= 9'(COLUMNS)) || ({1'b0, y} >= 9'(ROWS));
   endfunction

   function automatic logic [ADDR_W-1:0] pix_addr(logic [7:0] x, logic [7:0] y);
      pix_addr = ADDR_W'(32'(y[7:3]) * COLUMNS + 32'(x));
   endfunction

endpackage

@@ rtl/mpfd_ram.sv @@
// ----------------------------------------------------------------------------
// mpfd_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module mpfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/mpfd_div.sv @@
// ----------------------------------------------------------------------------
// mpfd_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mpfd_div
   import mpfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quot,
   output div_stat_type     stat
);

   localparam int CNT_W = $clog2(NUM_W);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [DEN_W:0]   rem_sh;
   logic             ge;

   always_comb begin
      rem_sh  = {rem_ff, num_ff[NUM_W-1]};
      ge      = rem_sh >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W - 1);
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
      end else if (busy_ff) begin
         // shift in one dividend bit, subtract when it fits
         rem_in = ge ? DEN_W'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_W-1:0];
         num_in = {num_ff[NUM_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign quot      = num_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

@@ rtl/monochrome_page_framebuffer_draw_top.sv @@
// ----------------------------------------------------------------------------
// monochrome_page_framebuffer_draw_top
// Page-mode monochrome frame store with fill, point, line, circle and read.
// ----------------------------------------------------------------------------
// One request is handled at a time; the single-port frame store sets the pace.
// After reset a clearing pass writes all PAGES*COLUMNS bytes before the first
// request is taken. Fill writes all PAGES*COLUMNS bytes; every plotted pixel
// takes a read-modify-write (an off-screen pixel is marked clipped and gets no
// access). Diagonal lines set up the slope with the divider first; a circle
// plots eight octant points per step of the rasterizer. The response waits in
// an output register, so the next request is taken while it waits; a finished
// request stalls in S_DONE only while an older response is still unaccepted.
module monochrome_page_framebuffer_draw_top
   import mpfd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_data
);

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_FILL  = 4'd2;
   localparam logic [3:0] S_RD    = 4'd3;
   localparam logic [3:0] S_WR    = 4'd4;
   localparam logic [3:0] S_LINIT = 4'd5;
   localparam logic [3:0] S_DIV   = 4'd6;
   localparam logic [3:0] S_SLQ   = 4'd7;
   localparam logic [3:0] S_SLR   = 4'd8;
   localparam logic [3:0] S_CINIT = 4'd9;
   localparam logic [3:0] S_CCOND = 4'd10;
   localparam logic [3:0] S_CUPD  = 4'd11;
   localparam logic [3:0] S_RDB   = 4'd12;
   localparam logic [3:0] S_RDBW  = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   localparam logic [2:0] PK_POINT = 3'd0;
   localparam logic [2:0] PK_VERT  = 3'd1;
   localparam logic [2:0] PK_HORZ  = 3'd2;
   localparam logic [2:0] PK_DIAG  = 3'd3;
   localparam logic [2:0] PK_CIRC  = 3'd4;

   logic [3:0]        state_ff, state_in;
   req_payload_type   cmd_ff, cmd_in;
   logic              clip_ff, clip_in;
   logic [7:0]        rdata_ff, rdata_in;
   logic [2:0]        pk_ff, pk_in;
   logic [7:0]        k_ff, k_in;
   logic [7:0]        cnt_ff, cnt_in;
   logic [7:0]        q_ff, q_in;
   logic [3:0]        r_ff, r_in;
   logic [7:0]        qs_ff, qs_in;
   logic [3:0]        rs_ff, rs_in;
   logic              neg_ff, neg_in;
   logic [7:0]        a_ff, a_in;
   logic [7:0]        b_ff, b_in;
   logic [16:0]       a2_ff, a2_in;
   logic [15:0]       b2_ff, b2_in;
   logic [15:0]       r2_ff, r2_in;
   logic [2:0]        oct_ff, oct_in;
   logic [ADDR_W-1:0] sweep_ff, sweep_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_payload_type   rsp_data_ff, rsp_data_in;

   logic [8:0]        dx, dy;
   logic [7:0]        dy_mag;
   logic [NUM_W-1:0]  div_num;
   logic [NUM_W-1:0]  slope_mag;
   logic              div_start;
   div_stat_type      div_stat;
   logic [24:0]       recip_prod;
   logic [7:0]        cur_x, cur_y;
   logic              cur_off;
   logic [4:0]        r_sum;
   logic [16:0]       a2_next;
   logic [7:0]        mask;

   logic              ram_we, ram_re;
   logic [ADDR_W-1:0] ram_addr;
   logic [7:0]        ram_wdata, ram_rdata;

   assign dx     = {1'b0, cmd_ff.x_end} - {1'b0, cmd_ff.x_start};
   assign dy     = {1'b0, cmd_ff.y_end} - {1'b0, cmd_ff.y_start};
   assign dy_mag = dy[8] ? 8'(-dy) : dy[7:0];
   assign div_num = (NUM_W'(dy_mag) << 3) + (NUM_W'(dy_mag) << 1);
   assign recip_prod = 25'(slope_mag) * 25'd6554;
   assign r_sum   = 5'(r_ff) + 5'(rs_ff);
   assign a2_next = a2_ff + 17'({a_ff, 1'b1});

   // current pixel of the running primitive
   always_comb begin
      cur_x = cmd_ff.x_start;
      cur_y = cmd_ff.y_start;
      case (pk_ff)
         PK_POINT: ;
         PK_VERT:  cur_y = cmd_ff.y_start + k_ff;
         PK_HORZ:  cur_x = cmd_ff.x_start + k_ff;
         PK_DIAG: begin
            cur_x = cmd_ff.x_start + k_ff;
            cur_y = neg_ff ? cmd_ff.y_start - q_ff : cmd_ff.y_start + q_ff;
         end
         PK_CIRC: begin
            case (oct_ff)
               3'd0: begin cur_x = cmd_ff.x_start + a_ff; cur_y = cmd_ff.y_start - b_ff; end
               3'd1: begin cur_x = cmd_ff.x_start - a_ff; cur_y = cmd_ff.y_start - b_ff; end
               3'd2: begin cur_x = cmd_ff.x_start - a_ff; cur_y = cmd_ff.y_start + b_ff; end
               3'd3: begin cur_x = cmd_ff.x_start + a_ff; cur_y = cmd_ff.y_start + b_ff; end
               3'd4: begin cur_x = cmd_ff.x_start + b_ff; cur_y = cmd_ff.y_start + a_ff; end
               3'd5: begin cur_x = cmd_ff.x_start + b_ff; cur_y = cmd_ff.y_start - a_ff; end
               3'd6: begin cur_x = cmd_ff.x_start - b_ff; cur_y = cmd_ff.y_start - a_ff; end
               default: begin
                  cur_x = cmd_ff.x_start - b_ff;
                  cur_y = cmd_ff.y_start + a_ff;
               end
            endcase
         end
         default: ;
      endcase
   end

   assign cur_off = off_screen(cur_x, cur_y);
   assign mask    = 8'(1) << cur_y[2:0];

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      clip_in      = clip_ff;
      rdata_in     = rdata_ff;
      pk_in        = pk_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      q_in         = q_ff;
      r_in         = r_ff;
      qs_in        = qs_ff;
      rs_in        = rs_ff;
      neg_in       = neg_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      a2_in        = a2_ff;
      b2_in        = b2_ff;
      r2_in        = r2_ff;
      oct_in       = oct_ff;
      sweep_in     = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      div_start    = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_addr     = pix_addr(cur_x, cur_y);
      ram_wdata    = cmd_ff.ink ? (ram_rdata | mask) : (ram_rdata & ~mask);
      case (state_ff)
         S_CLEAR, S_FILL: begin
            ram_we    = 1'b1;
            ram_addr  = sweep_ff;
            ram_wdata = (state_ff == S_FILL && cmd_ff.ink) ? FILL_ONES : FILL_ZEROS;
            sweep_in  = sweep_ff + 1'b1;
            if (sweep_ff == ADDR_W'(DEPTH - 1)) begin
               sweep_in = '0;
               state_in = (state_ff == S_FILL) ? S_DONE : S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_data;
               clip_in  = 1'b0;
               rdata_in = '0;
               pk_in    = PK_POINT;
               k_in     = '0;
               q_in     = '0;
               r_in     = '0;
               oct_in   = '0;
               sweep_in = '0;
               case (req_data.action)
                  ACT_FILL:   state_in = S_FILL;
                  ACT_POINT:  state_in = S_RD;
                  ACT_LINE:   state_in = S_LINIT;
                  ACT_CIRCLE: state_in = S_CINIT;
                  ACT_READ:   state_in = S_RDB;
                  default:    state_in = S_DONE;
               endcase
            end
         end
         S_LINIT: begin
            state_in = S_DONE;
            if (cmd_ff.x_start == cmd_ff.x_end) begin
               if (!dy[8] && dy != '0) begin
                  pk_in    = PK_VERT;
                  cnt_in   = dy[7:0];
                  state_in = S_RD;
               end
            end else if (cmd_ff.y_start == cmd_ff.y_end) begin
               if (!dx[8]) begin
                  pk_in    = PK_HORZ;
                  cnt_in   = dx[7:0];
                  state_in = S_RD;
               end
            end else if (!dx[8]) begin
               pk_in     = PK_DIAG;
               cnt_in    = dx[7:0];
               neg_in    = dy[8];
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               state_in = S_SLQ;
            end
         end
         S_SLQ: begin
            // slope / 10 by reciprocal, exact for slopes up to 2559
            qs_in    = recip_prod[23:16];
            state_in = S_SLR;
         end
         S_SLR: begin
            rs_in    = 4'(slope_mag - (NUM_W'(qs_ff) << 3) - (NUM_W'(qs_ff) << 1));
            state_in = S_RD;
         end
         S_CINIT: begin
            if (cmd_ff.radius == '0) begin
               state_in = S_RD;
            end else begin
               pk_in    = PK_CIRC;
               r2_in    = 16'(cmd_ff.radius) * 16'(cmd_ff.radius);
               b2_in    = 16'(cmd_ff.radius) * 16'(cmd_ff.radius);
               a_in     = '0;
               a2_in    = '0;
               b_in     = cmd_ff.radius;
               state_in = S_CCOND;
            end
         end
         S_CCOND: begin
            oct_in   = '0;
            state_in = ({b2_ff, 1'b0} >= {1'b0, r2_ff}) ? S_RD : S_DONE;
         end
         S_CUPD: begin
            if (18'(a2_next) + 18'(b2_ff) > 18'(r2_ff)) begin
               b_in  = b_ff - 1'b1;
               b2_in = b2_ff - 16'({b_ff, 1'b0}) + 16'd1;
            end else begin
               a_in  = a_ff + 1'b1;
               a2_in = a2_next;
            end
            state_in = S_CCOND;
         end
         S_RD, S_WR: begin
            if (state_ff == S_RD && !cur_off) begin
               ram_re   = 1'b1;
               state_in = S_WR;
            end else begin
               if (state_ff == S_RD) begin
                  clip_in = 1'b1;
               end else begin
                  ram_we = 1'b1;
               end
               // advance to the next pixel
               state_in = S_RD;
               case (pk_ff)
                  PK_POINT: state_in = S_DONE;
                  PK_CIRC: begin
                     oct_in = oct_ff + 1'b1;
                     if (oct_ff == 3'd7) begin
                        state_in = S_CUPD;
                     end
                  end
                  default: begin
                     k_in = k_ff + 1'b1;
                     if (r_sum >= 5'd10) begin
                        r_in = 4'(r_sum - 5'd10);
                        q_in = q_ff + qs_ff + 1'b1;
                     end else begin
                        r_in = r_sum[3:0];
                        q_in = q_ff + qs_ff;
                     end
                     if (k_ff == cnt_ff - 1'b1) begin
                        state_in = S_DONE;
                     end
                  end
               endcase
            end
         end
         S_RDB: begin
            ram_addr = pix_addr(cmd_ff.x_start, cmd_ff.y_start);
            if (off_screen(cmd_ff.x_start, cmd_ff.y_start)) begin
               clip_in  = 1'b1;
               state_in = S_DONE;
            end else begin
               ram_re   = 1'b1;
               state_in = S_RDBW;
            end
         end
         S_RDBW: begin
            rdata_in = ram_rdata;
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.read_data = rdata_ff;
               rsp_data_in.clipped   = clip_ff;
               state_in              = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      clip_ff     <= clip_in;
      rdata_ff    <= rdata_in;
      pk_ff       <= pk_in;
      k_ff        <= k_in;
      cnt_ff      <= cnt_in;
      q_ff        <= q_in;
      r_ff        <= r_in;
      qs_ff       <= qs_in;
      rs_ff       <= rs_in;
      neg_ff      <= neg_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      a2_ff       <= a2_in;
      b2_ff       <= b2_in;
      r2_ff       <= r2_in;
      oct_ff      <= oct_in;
      rsp_data_ff <= rsp_data_in;
   end

   mpfd_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (dx[7:0]),
      .quot  (slope_mag),
      .stat  (div_stat)
   );

   mpfd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .rd_en   (ram_re),
      .addr    (ram_addr),
      .wr_data (ram_wdata),
      .rd_data (ram_rdata)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/mpfd_chk.sv @@
// ----------------------------------------------------------------------------
// mpfd_chk
// Port-level checks for the frame store drawing block, bound to the top.
// ----------------------------------------------------------------------------
`include "monochrome_page_framebuffer_draw_top_defines.svh"

module mpfd_chk
   import mpfd_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input rsp_payload_type rsp_data
);

   // hold a stalled response
   `MPFD_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")
   // the clearing pass follows reset
   `MPFD_ASSERT_ALWAYS(a_clear_after_reset, reset |=> !req_ready, "request taken during clearing pass")
   // one request at a time
   `MPFD_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second request taken back to back")
   // a new response comes only out of a busy period
   `MPFD_ASSERT(a_rsp_after_work, $rose(rsp_valid) |-> $past(!req_ready), "response without work")

endmodule

bind monochrome_page_framebuffer_draw_top mpfd_chk u_chk (.*);
